### rtl/olist_pkg.sv
// Package for the ordered list engine: command and status codes, and the
// control and flag structs passed between the top level and its storage cells.
// No dependencies.
package olist_pkg;

  // Widest position or count that any supported capacity needs (capacity up to 2047).
  localparam int POS_W  = 11;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_DELETE_VAL = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_COUNT      = 3'd6
  } command_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Broadcast control seen by every cell of the chain.
  typedef struct packed {
    logic              load;     // capture per-cell flags for a new request
    logic              ins_en;   // open a gap at ins_pos and write value there
    logic              del_en;   // cells flagged by del_shift take their right neighbor
    logic [POS_W-1:0]  ins_pos;
    logic [POS_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  // Flags a cell captures when a request is loaded.
  typedef struct packed {
    logic match;  // holds an entry equal to the request value
    logic tail;   // is the last held entry
  } cell_flags_t;

endpackage

### rtl/olist_cell.sv
// One storage cell of the ordered list chain.
// Depends on olist_pkg for the control and flag structs.
module olist_cell import olist_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic              del_shift,
  output logic [DATA_W-1:0] data,
  output cell_flags_t       flags
);

  localparam logic [POS_W-1:0] MY_IDX  = POS_W'(INDEX);
  localparam logic [POS_W-1:0] MY_NEXT = POS_W'(INDEX + 1);

  // Flags are captured on load; the entry shifts or takes the new value on update.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      flags.match <= (data == ctrl.value) && (MY_IDX < ctrl.count);
      flags.tail  <= (ctrl.count == MY_NEXT);
    end
    if (ctrl.ins_en) begin
      if (MY_IDX > ctrl.ins_pos) begin
        data <= left_data;
      end else if (MY_IDX == ctrl.ins_pos) begin
        data <= ctrl.value;
      end
    end else if (ctrl.del_en && del_shift) begin
      data <= right_data;
    end
  end

endmodule

### rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: control, result register and the cell chain.
// Depends on olist_pkg and olist_cell.
//
// Usage:
//   A request carries command, value and position on a valid/ready channel. Each
//   request gives exactly one result (status, removed_value, entry_count) on a
//   valid/ready output channel.
//   A request has a load step and an update step: on load every cell
//   compares its entry with the request value and notes whether it is the
//   tail; on update the chain shifts by one place (right for a push or
//   insert, left for a delete or front pop) and the result is written to the
//   output register. The next request is accepted in the cycle after that, so
//   a new request is not taken until the update of the last one is done.
//   A request is accepted even while a result waits at the output; if the
//   receiver stalls, the update cycle waits until the output register is free.
//   Reset empties the list and clears both handshakes; entry contents are not
//   cleared, since no entry beyond the count is ever read.
module ordered_list_engine_unit import olist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         command,
  input  logic signed [DATA_W-1:0]           value,
  input  logic [$clog2(CAPACITY+1)-1:0]      position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic signed [DATA_W-1:0]           removed_value,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic {
    S_LOAD,
    S_EXEC
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   held_count;
  logic [CNT_W-1:0]   held_count_next;
  logic [2:0]         cmd_q;
  logic [DATA_W-1:0]  val_q;
  logic [CNT_W-1:0]   pos_q;

  logic               accept;
  logic               exec_fire;
  cell_ctrl_t         ctrl;
  logic [DATA_W-1:0]  cell_data [CAPACITY];
  cell_flags_t        cell_flags [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] shift_vec;
  logic [DATA_W-1:0]  tail_value;

  logic [CNT_W-1:0]   ins_pos;
  logic               ins_ok;
  logic               del_ok;
  logic [2:0]         status_next;
  logic [DATA_W-1:0]  removed_next;

  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign exec_fire = (state == S_EXEC) && (!out_valid || out_ready);

  // Gather match bits and pick the tail entry with an AND-OR over the cells.
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = cell_flags[i].match;
      tail_value   = tail_value | (cell_data[i] & {DATA_W{cell_flags[i].tail}});
    end
  end

  // A prefix OR shifts cells left from the first match on; a front pop shifts all.
  always_comb begin
    logic [CAPACITY-1:0] pre;
    pre = match_vec;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      pre = pre | (pre << s);
    end
    shift_vec = (cmd_q == CMD_POP_FRONT) ? {CAPACITY{1'b1}} : pre;
  end

  // Decode the loaded request into status, removed value and the chain update.
  always_comb begin
    ins_pos      = pos_q;
    ins_ok       = 1'b0;
    del_ok       = 1'b0;
    status_next  = ST_OK;
    removed_next = '0;
    case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (cmd_q == CMD_PUSH_FRONT) begin
          ins_pos = '0;
        end else if (cmd_q == CMD_PUSH_BACK) begin
          ins_pos = held_count;
        end
        if (ins_pos > held_count) begin
          status_next = ST_BAD_POS;
        end else if (held_count >= CAP_CNT) begin
          status_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      CMD_DELETE_VAL: begin
        if (|match_vec) begin
          del_ok       = 1'b1;
          removed_next = val_q;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      CMD_POP_FRONT: begin
        if (held_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          del_ok       = 1'b1;
          removed_next = cell_data[0];
        end
      end
      CMD_POP_BACK: begin
        if (held_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          removed_next = tail_value;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase

    held_count_next = held_count;
    if (ins_ok) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (status_next == ST_OK &&
                 (cmd_q == CMD_DELETE_VAL || cmd_q == CMD_POP_FRONT ||
                  cmd_q == CMD_POP_BACK)) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  // Broadcast control to the chain.
  always_comb begin
    ctrl.load    = accept;
    ctrl.ins_en  = exec_fire && ins_ok;
    ctrl.del_en  = exec_fire && del_ok;
    ctrl.ins_pos = POS_W'(ins_pos);
    ctrl.count   = POS_W'(held_count);
    ctrl.value   = accept ? DATA_W'(value) : val_q;
  end

  // The chain of cells, each linked to its left and right neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = cell_data[g];
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    olist_cell #(
      .INDEX(g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_in),
      .right_data (right_in),
      .del_shift  (shift_vec[g]),
      .data       (cell_data[g]),
      .flags      (cell_flags[g])
    );
  end

  // Sequencer, held count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !exec_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            cmd_q <= command;
            val_q <= value;
            pos_q <= position;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            held_count    <= held_count_next;
            status        <= status_next;
            removed_value <= removed_next;
            entry_count   <= held_count_next;
            out_valid     <= 1'b1;
            state         <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

### rtl/olist_checker.sv
// Port-level checker for the ordered list engine, bound to its top level.
// Depends on olist_pkg and ordered_list_engine_unit.
module olist_checker import olist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    status,
  input logic [DATA_W-1:0]             removed_value,
  input logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // A result never reports more entries than the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(CAPACITY)))
    else $error("entry_count above capacity");

  // A full status only comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
    else $error("full status with a list that is not full");

  // An empty status leaves an empty list and removes nothing.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (entry_count == '0 && removed_value == '0))
    else $error("empty status with entries or a removed value");

  // A request is followed by its update cycle, so ready drops after acceptance.
  a_ready_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted in consecutive cycles");

endmodule

bind ordered_list_engine_unit olist_checker #(
  .CAPACITY(CAPACITY)
) u_olist_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .removed_value (removed_value),
  .entry_count   (entry_count)
);
